[rtl/dual_motor_soft_start_sequencer_core_assert.svh]
// Assertion macros used by the checker file of the soft-start sequencer.
`ifndef DUAL_MOTOR_SOFT_START_SEQUENCER_CORE_ASSERT_SVH
`define DUAL_MOTOR_SOFT_START_SEQUENCER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DMSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define DMSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define DMSS_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dmss_pkg.sv]
`default_nettype none

package dmss_pkg;

  localparam int DUTY_W     = 10;
  localparam int TIMER_W    = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (TIMER_W > DUTY_W) ? TIMER_W : DUTY_W;

  typedef logic [DUTY_W-1:0]  duty_t;
  typedef logic [TIMER_W-1:0] timer_t;

  // Operation codes of an input transfer. Code 3 leaves the state unchanged.
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_DUTY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_DELAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TIME   = 3'd6;

  localparam duty_t  RST_MAX_DUTY     = 10'd1023;
  localparam duty_t  RST_MIN_DUTY     = 10'd0;
  localparam duty_t  RST_STARTUP_DUTY = 10'd716;
  localparam timer_t RST_SYNC_DELAY   = 16'd5;
  localparam timer_t RST_STARTUP_TIME = 16'd300;
  localparam timer_t RST_STEP_TIME    = 16'd20;
  localparam timer_t RST_PAUSE_TIME   = 16'd100;

  // Ramp steps are fine-grained when the distance is below this.
  localparam duty_t RAMP_NEAR = 10'd5;
  // v / 20 is computed as (v >> 2) / 5, with / 5 done as * 52429 >> 18,
  // which is exact for every quotient input below 81920.
  localparam int DIV5_MUL   = 52429;
  localparam int DIV5_SHIFT = 18;
  localparam int QUART_W    = DUTY_W - 2;
  localparam int PROD_W     = QUART_W + 16;

  typedef enum logic [1:0] {
    DIR_STOP  = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_BWD   = 2'd2,
    DIR_BRAKE = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_STOP_SYNC  = 3'd1,
    PH_REV_SYNC   = 3'd2,
    PH_PAUSE      = 3'd3,
    PH_START_SYNC = 3'd4,
    PH_STARTUP    = 3'd5,
    PH_RAMP       = 3'd6
  } phase_t;

  typedef struct packed {
    duty_t  max_duty;
    duty_t  min_duty;
    duty_t  startup_duty;
    timer_t sync_delay;
    timer_t startup_time;
    timer_t step_time;
    timer_t pause_time;
  } cfg_t;

  // Both motors always carry the same duty, so one duty register serves both.
  typedef struct packed {
    phase_t phase;
    timer_t wait_cnt;
    duty_t  ramp_val;
    duty_t  ramp_tgt;
    dir_t   pend_a;
    dir_t   pend_b;
    dir_t   dir_a;
    dir_t   dir_b;
    duty_t  duty;
  } state_t;

  typedef struct packed {
    logic  pin_a1;
    logic  pin_a2;
    logic  pin_b1;
    logic  pin_b2;
    duty_t duty_a;
    duty_t duty_b;
    logic  busy;
  } result_t;

  function automatic duty_t div20(input duty_t v);
    logic [QUART_W-1:0] quart;
    logic [PROD_W-1:0]  prod;
    quart = v[DUTY_W-1:2];
    prod  = PROD_W'(quart) * PROD_W'(DIV5_MUL);
    return DUTY_W'(prod >> DIV5_SHIFT);
  endfunction

  // Cap at the maximum first, then raise a nonzero duty to the floor.
  function automatic duty_t apply_duty(input duty_t v, input cfg_t cfg);
    duty_t d;
    d = (v > cfg.max_duty) ? cfg.max_duty : v;
    if ((d != '0) && (d < cfg.min_duty)) begin
      d = cfg.min_duty;
    end
    return d;
  endfunction

  function automatic logic pin_one(input dir_t d);
    return (d == DIR_FWD) || (d == DIR_BRAKE);
  endfunction

  function automatic logic pin_two(input dir_t d);
    return (d == DIR_BWD) || (d == DIR_BRAKE);
  endfunction

endpackage

`default_nettype wire

[rtl/dual_motor_soft_start_sequencer_core.sv]
// Each transfer's result is registered before it appears on the out_ channel.
// One item per cycle while in_ready is high; the state is updated in a single pass.
// A two-entry result buffer keeps in_ready high while one result waits downstream.
// Reset (rst_n low, synchronous): idle, both motors stopped at zero duty, all
// configuration registers back to their documented defaults, no result pending.
`default_nettype none

module dual_motor_soft_start_sequencer_core
  import dmss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [1:0]            in_dir_a,
  input  logic [1:0]            in_dir_b,
  input  logic [DUTY_W-1:0]     in_target_duty,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_pin_a1,
  output logic                  out_pin_a2,
  output logic                  out_pin_b1,
  output logic                  out_pin_b2,
  output logic [DUTY_W-1:0]     out_duty_a,
  output logic [DUTY_W-1:0]     out_duty_b,
  output logic                  out_busy_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The sequencer state lives in one struct register. Every accepted transfer
  // (a tick, a move or a stop) moves it forward exactly once.
  state_t  state_r, state_nxt;
  cfg_t    cfg_r;
  result_t res_nxt;
  result_t res_out;
  logic    in_xfer;

  assign in_xfer = in_valid && in_ready;

  // The whole sequencing decision for one transfer is short combinational
  // logic: a timer compare, a ramp step with a constant divide, and the
  // duty cap and floor.
  dmss_step u_step (
    .st     (state_r),
    .cfg    (cfg_r),
    .op     (in_operation),
    .dir_a  (dir_t'(in_dir_a)),
    .dir_b  (dir_t'(in_dir_b)),
    .target (in_target_duty),
    .nxt    (state_nxt)
  );

  // The result always reflects the state after the transfer, so it is formed
  // from the next-state value and captured together with the state update.
  always_comb begin
    res_nxt.pin_a1 = pin_one(state_nxt.dir_a);
    res_nxt.pin_a2 = pin_two(state_nxt.dir_a);
    res_nxt.pin_b1 = pin_one(state_nxt.dir_b);
    res_nxt.pin_b2 = pin_two(state_nxt.dir_b);
    res_nxt.duty_a = state_nxt.duty;
    res_nxt.duty_b = state_nxt.duty;
    res_nxt.busy   = (state_nxt.phase != PH_IDLE);
  end

  // Result register plus skid entry. Its free slot is what in_ready reports.
  dmss_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (res_nxt),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (res_out)
  );

  assign out_pin_a1   = res_out.pin_a1;
  assign out_pin_a2   = res_out.pin_a2;
  assign out_pin_b1   = res_out.pin_b1;
  assign out_pin_b2   = res_out.pin_b2;
  assign out_duty_a   = res_out.duty_a;
  assign out_duty_b   = res_out.duty_b;
  assign out_busy_res = res_out.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase    <= PH_IDLE;
      state_r.wait_cnt <= '0;
      state_r.ramp_val <= '0;
      state_r.ramp_tgt <= '0;
      state_r.pend_a   <= DIR_STOP;
      state_r.pend_b   <= DIR_STOP;
      state_r.dir_a    <= DIR_STOP;
      state_r.dir_b    <= DIR_STOP;
      state_r.duty     <= '0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers. The user must issue writes only while the sequencer
  // is idle; the block does not enforce it. Writes apply at once, no hold-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_duty     <= RST_MAX_DUTY;
      cfg_r.min_duty     <= RST_MIN_DUTY;
      cfg_r.startup_duty <= RST_STARTUP_DUTY;
      cfg_r.sync_delay   <= RST_SYNC_DELAY;
      cfg_r.startup_time <= RST_STARTUP_TIME;
      cfg_r.step_time    <= RST_STEP_TIME;
      cfg_r.pause_time   <= RST_PAUSE_TIME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DUTY:     cfg_r.max_duty     <= cfg_wdata[DUTY_W-1:0];
        REG_MIN_DUTY:     cfg_r.min_duty     <= cfg_wdata[DUTY_W-1:0];
        REG_STARTUP_DUTY: cfg_r.startup_duty <= cfg_wdata[DUTY_W-1:0];
        REG_SYNC_DELAY:   cfg_r.sync_delay   <= cfg_wdata[TIMER_W-1:0];
        REG_STARTUP_TIME: cfg_r.startup_time <= cfg_wdata[TIMER_W-1:0];
        REG_STEP_TIME:    cfg_r.step_time    <= cfg_wdata[TIMER_W-1:0];
        REG_PAUSE_TIME:   cfg_r.pause_time   <= cfg_wdata[TIMER_W-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/dmss_step.sv]
`default_nettype none

module dmss_step
  import dmss_pkg::*;
(
  input  state_t          st,
  input  cfg_t            cfg,
  input  logic [OP_W-1:0] op,
  input  dir_t            dir_a,
  input  dir_t            dir_b,
  input  duty_t           target,
  output state_t          nxt
);

  logic   idle;
  logic   fire;
  logic   change;
  logic   at_target;
  logic   ramp_up;
  duty_t  span;
  duty_t  quot;
  duty_t  step;
  duty_t  ramp_nxt;
  phase_t phase_nxt;

  assign idle      = (st.phase == PH_IDLE);
  assign fire      = !idle && (st.wait_cnt <= timer_t'(1));
  assign change    = (st.duty != '0) && ((st.dir_a != dir_a) || (st.dir_b != dir_b));
  assign at_target = (st.ramp_val == st.ramp_tgt);

  // One ramp step, clamped so it never passes the target.
  always_comb begin
    ramp_up = (st.ramp_val <= st.ramp_tgt);
    span    = ramp_up ? (st.ramp_tgt - st.ramp_val) : (st.ramp_val - st.ramp_tgt);
    quot    = div20(st.ramp_val);
    if (span < RAMP_NEAR) begin
      step = duty_t'(1);
    end else if (quot == '0) begin
      step = duty_t'(1);
    end else begin
      step = quot;
    end
    if (span < step) begin
      ramp_nxt = st.ramp_tgt;
    end else if (ramp_up) begin
      ramp_nxt = st.ramp_val + step;
    end else begin
      ramp_nxt = st.ramp_val - step;
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = st.phase;
    case (op)
      OP_TICK: begin
        if (fire) begin
          unique case (st.phase) inside
            PH_STOP_SYNC:         phase_nxt = PH_IDLE;
            PH_REV_SYNC:          phase_nxt = PH_PAUSE;
            PH_PAUSE:             phase_nxt = PH_START_SYNC;
            PH_START_SYNC:        phase_nxt = PH_STARTUP;
            PH_STARTUP, PH_RAMP:  phase_nxt = at_target ? PH_IDLE : PH_RAMP;
            default:              phase_nxt = PH_IDLE;
          endcase
        end
      end
      OP_MOVE: begin
        if (idle) begin
          phase_nxt = change ? PH_REV_SYNC : PH_START_SYNC;
        end
      end
      OP_STOP: begin
        if (idle) begin
          phase_nxt = PH_STOP_SYNC;
        end
      end
      default: phase_nxt = st.phase;
    endcase
  end

  // Counters, ramp, directions and duty.
  always_comb begin
    nxt       = st;
    nxt.phase = phase_nxt;
    case (op)
      OP_TICK: begin
        if (!idle && !fire) begin
          nxt.wait_cnt = st.wait_cnt - timer_t'(1);
        end else if (fire) begin
          nxt.wait_cnt = '0;
          unique case (st.phase) inside
            PH_STOP_SYNC: begin
              nxt.dir_a = DIR_STOP;
              nxt.dir_b = DIR_STOP;
            end
            PH_REV_SYNC: begin
              nxt.dir_a    = DIR_STOP;
              nxt.dir_b    = DIR_STOP;
              nxt.wait_cnt = cfg.pause_time;
            end
            PH_PAUSE: begin
              nxt.dir_a    = st.pend_a;
              nxt.dir_b    = st.pend_b;
              nxt.wait_cnt = cfg.sync_delay;
            end
            PH_START_SYNC: begin
              nxt.ramp_val = cfg.startup_duty;
              nxt.duty     = apply_duty(cfg.startup_duty, cfg);
              nxt.wait_cnt = cfg.startup_time;
            end
            PH_STARTUP, PH_RAMP: begin
              if (!at_target) begin
                nxt.ramp_val = ramp_nxt;
                nxt.duty     = apply_duty(ramp_nxt, cfg);
                nxt.wait_cnt = cfg.step_time;
              end
            end
            default: nxt.wait_cnt = '0;
          endcase
        end
      end
      OP_MOVE: begin
        if (idle) begin
          nxt.pend_a   = dir_a;
          nxt.pend_b   = dir_b;
          nxt.ramp_tgt = target;
          nxt.wait_cnt = cfg.sync_delay;
          if (change) begin
            nxt.duty = '0;
          end else begin
            nxt.dir_a = dir_a;
            nxt.dir_b = dir_b;
          end
        end
      end
      OP_STOP: begin
        if (idle) begin
          nxt.duty     = '0;
          nxt.wait_cnt = cfg.sync_delay;
        end
      end
      default: nxt = st;
    endcase
  end

endmodule

`default_nettype wire

[rtl/dmss_out_buf.sv]
`default_nettype none

module dmss_out_buf
  import dmss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  result_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_data_r, main_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;
  logic    push;

  assign push_ready = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_data_r;
  assign pop        = main_valid_r && pop_ready;
  assign push       = push_valid && push_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

[rtl/dmss_checker.sv]
`default_nettype none

`include "dual_motor_soft_start_sequencer_core_assert.svh"

module dmss_checker
  import dmss_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [OP_W-1:0]       in_operation,
  input wire logic [1:0]            in_dir_a,
  input wire logic [1:0]            in_dir_b,
  input wire logic [DUTY_W-1:0]     in_target_duty,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_pin_a1,
  input wire logic                  out_pin_a2,
  input wire logic                  out_pin_b1,
  input wire logic                  out_pin_b2,
  input wire logic [DUTY_W-1:0]     out_duty_a,
  input wire logic [DUTY_W-1:0]     out_duty_b,
  input wire logic                  out_busy_res,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // A stalled result must hold its value until it is taken.
  `DMSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_duty_a) && $stable(out_busy_res) && $stable(out_pin_a1),
    "stalled result changed")

  // Both motors share one duty in every result.
  `DMSS_ASSERT_IMP(a_duty_shared, out_valid, out_duty_a == out_duty_b,
    "motor duties differ")

  // The input side only stalls when a result is already waiting.
  `DMSS_ASSERT_IMP(a_ready_backlog, !in_ready, out_valid,
    "input stalled with no result pending")

  // No result is left over from before reset.
  `DMSS_ASSERT_RST(a_reset_empty, !rst_n, !out_valid,
    "result valid right after reset")

endmodule

bind dual_motor_soft_start_sequencer_core dmss_checker u_dmss_checker (.*);

`default_nettype wire
